[design/vsk_pkg.sv]
package vsk_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // serial multiplier: signed multiplicand times unsigned multiplier
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    typedef enum logic [2:0] {
        REG_PROCESS_NOISE     = 3'd0,
        REG_MEASUREMENT_NOISE = 3'd1,
        REG_WHEEL_RADIUS      = 3'd2,
        REG_SLIP_GATE         = 3'd3,
        REG_REJECT_GAIN       = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic [MUL_BW-1:0]        b;
    } t_mul_req;

    function automatic logic signed [31:0] sat32(input logic signed [MUL_PW-1:0] x);
        logic signed [MUL_PW-1:0] hi;
        logic signed [MUL_PW-1:0] lo;
        hi = MUL_PW'(32'sh7FFF_FFFF);
        lo = -MUL_PW'(33'sh0_8000_0000);
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

[design/vsk_in_if.sv]
interface vsk_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] front_left_rate;
    logic signed [31:0] front_right_rate;
    logic signed [31:0] longitudinal_accel;
    logic signed [31:0] time_step;

    modport source (output valid, front_left_rate, front_right_rate,
                    longitudinal_accel, time_step, input ready);
    modport sink (input valid, front_left_rate, front_right_rate,
                  longitudinal_accel, time_step, output ready);
endinterface

[design/vsk_out_if.sv]
interface vsk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] speed_estimate;

    modport source (output valid, speed_estimate, input ready);
    modport sink (input valid, speed_estimate, output ready);
endinterface

[design/vsk_mul.sv]
module vsk_mul
    import vsk_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_req                 i_req,
    output logic                     o_done,
    output logic signed [MUL_PW-1:0] o_prod
);

    localparam int CW = $clog2(MUL_BW);

    logic                     r_busy;
    logic                     r_done;
    logic [CW-1:0]            r_cnt;
    logic signed [MUL_PW-1:0] r_acc;
    logic signed [MUL_PW-1:0] r_a;
    logic [MUL_BW-1:0]        r_b;

    // one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= MUL_PW'(i_req.a);
                r_b    <= i_req.b;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[design/vsk_div.sv]
module vsk_div #(
    parameter int NW = 48,
    parameter int DW = 41
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [DW:0]   rem_sh;
    logic          take;

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign take   = rem_sh >= {1'b0, r_den};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem  <= take ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
                r_quo  <= {r_quo[NW-2:0], take};
                r_num  <= r_num << 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[design/vehicle_speed_kalman_estimator_unit.sv]
// processing: a nonpositive time step skips the filter and resends the held speed; otherwise
//   four passes through the bit-serial multiplier (five when the gate trips) and one
//   pass through the divider, with control states between them
// throughput: one item at a time, the next beat can be taken the cycle after the result is
//   registered
// reset (synchronous, active low): speed 0, variance 1.0, registers to their defaults
module vehicle_speed_kalman_estimator_unit
    import vsk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vsk_in_if.sink      i_in,
    vsk_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int RW = 40;
    localparam int DW = RW + 1;
    localparam int KW = FRAC_BITS + 1;
    localparam logic [KW-1:0] ONE = KW'(1) << FRAC_BITS;
    localparam logic [31:0] PN_RST = 32'((64'(3277) << FRAC_BITS) >> 16);
    localparam logic [31:0] MN_RST = 32'((64'(32768) << FRAC_BITS) >> 16);
    localparam logic [31:0] WR_RST = 32'((64'(16646) << FRAC_BITS) >> 16);
    localparam logic [31:0] SG_RST = 32'((64'(131072) << FRAC_BITS) >> 16);

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_GATE, S_M3, S_M3W, S_DEN, S_DIV, S_M4, S_M4W, S_M5, S_OUT
    } t_state;

    t_state r_state;

    logic [31:0] r_pn, r_mn, r_wr, r_sg;
    logic [7:0]  r_rg;

    logic signed [31:0] r_speed;
    logic [31:0]        r_var;

    logic signed [31:0] r_mean, r_v, r_meas;
    logic [31:0]        r_p;
    logic signed [33:0] r_innov;
    logic [RW-1:0]      r_r;
    logic [DW-1:0]      r_den;
    logic [KW-1:0]      r_k;

    logic               r_out_valid;
    logic signed [31:0] r_out;

    t_mul_req                 r_mreq;
    logic                     mul_done;
    logic signed [MUL_PW-1:0] mul_prod;
    logic signed [MUL_PW-1:0] prod_sh;
    logic                     r_div_start;
    logic                     div_done;
    logic [NW-1:0]            div_quo;

    logic               in_beat;
    logic [32:0]        psum;
    logic signed [32:0] rsum;
    logic signed [33:0] mag;

    assign in_beat    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign prod_sh    = mul_prod >>> FRAC_BITS;
    assign psum       = {1'b0, r_var} + {1'b0, r_pn};
    assign rsum       = 33'(i_in.front_left_rate) + 33'(i_in.front_right_rate);
    assign mag        = r_innov[33] ? -r_innov : r_innov;

    vsk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    vsk_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   ({r_p, {FRAC_BITS{1'b0}}}),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn        <= PN_RST;
            r_mn        <= MN_RST;
            r_wr        <= WR_RST;
            r_sg        <= SG_RST;
            r_rg        <= 8'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROCESS_NOISE:     r_pn <= i_cfg_data;
                REG_MEASUREMENT_NOISE: r_mn <= i_cfg_data;
                REG_WHEEL_RADIUS:      r_wr <= i_cfg_data;
                REG_SLIP_GATE:         r_sg <= i_cfg_data;
                REG_REJECT_GAIN:       r_rg <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_speed      <= '0;
            r_var        <= 32'(ONE);
            r_out_valid  <= 1'b0;
            r_mreq.start <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            r_div_start  <= 1'b0;
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_mean <= rsum[32:1];
                        if (i_in.time_step[31] || i_in.time_step == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_mreq <= '{start: 1'b1, a: 34'(i_in.longitudinal_accel),
                                        b: i_in.time_step};
                            r_state <= S_M1;
                        end
                    end
                end
                S_M1: begin
                    if (mul_done) begin
                        r_v <= sat32(prod_sh + MUL_PW'(r_speed));
                        r_p <= psum[32] ? 32'hFFFF_FFFF : psum[31:0];
                        r_mreq  <= '{start: 1'b1, a: 34'(r_mean), b: r_wr};
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    if (mul_done) begin
                        r_meas  <= sat32(prod_sh);
                        r_state <= S_GATE;
                    end
                end
                S_GATE: begin
                    r_innov <= 34'(r_meas) - 34'(r_v);
                    r_state <= S_M3;
                end
                S_M3: begin
                    // innovation beyond the gate: scale the noise by the reject factor
                    if (mag > 34'(r_sg)) begin
                        r_mreq  <= '{start: 1'b1, a: 34'(r_mn), b: 32'(r_rg)};
                        r_state <= S_M3W;
                    end else begin
                        r_r     <= RW'(r_mn);
                        r_state <= S_DEN;
                    end
                end
                S_M3W: begin
                    if (mul_done) begin
                        r_r     <= mul_prod[RW-1:0];
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_den       <= {1'b0, r_r} + DW'(r_p);
                    r_state     <= S_DIV;
                    r_div_start <= 1'b1;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_den == '0) begin
                            r_k <= '0;
                        end else if (div_quo > NW'(ONE)) begin
                            r_k <= ONE;
                        end else begin
                            r_k <= div_quo[KW-1:0];
                        end
                        r_state <= S_M4;
                    end
                end
                S_M4: begin
                    r_mreq  <= '{start: 1'b1, a: r_innov, b: 32'(r_k)};
                    r_state <= S_M4W;
                end
                S_M4W: begin
                    if (mul_done) begin
                        r_v     <= sat32(prod_sh + MUL_PW'(r_v));
                        r_mreq  <= '{start: 1'b1, a: 34'({2'b00, r_p}),
                                     b: 32'(ONE - r_k)};
                        r_state <= S_M5;
                    end
                end
                S_M5: begin
                    if (mul_done) begin
                        r_speed <= r_v;
                        r_var   <= mul_prod[FRAC_BITS +: 32];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_speed;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.speed_estimate = r_out;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import vsk_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1600;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] UNUSED_IDX = 3'd6;

    typedef struct packed {
        logic signed [31:0] fl;
        logic signed [31:0] fr;
        logic signed [31:0] ax;
        logic signed [31:0] dt;
    } t_wheel_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;

    vsk_in_if  in_ch ();
    vsk_out_if out_ch ();

    vehicle_speed_kalman_estimator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and registers
    logic [31:0]        q_noise, r_noise, radius, gate;
    logic [7:0]         rej_gain;
    logic signed [31:0] speed_pred;
    logic [31:0]        var_pred;

    t_wheel_beat        pending_beats[$];
    logic signed [31:0] expected_speeds[$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    bit                 run_done = 1'b0;
    bit                 in_fired = 1'b0;

    function automatic logic signed [63:0] floor_sh(input logic signed [63:0] x, input int s);
        return x >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -66'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    task automatic kalman_predict(input t_wheel_beat b);
        logic signed [65:0] v, meas, innov, mean, upd;
        logic [65:0]        p, r, den, k, mag;
        logic [65:0]        one;
        one = 66'd1 << FB;
        if (b.dt > 0) begin
            v = clamp32(66'(speed_pred) + 66'(floor_sh(64'(b.ax) * 64'(b.dt), FB)));
            p = 66'(var_pred) + 66'(q_noise);
            if (p > 66'hFFFF_FFFF) p = 66'hFFFF_FFFF;
            mean = (66'(b.fl) + 66'(b.fr)) >>> 1;
            meas = clamp32((mean * $signed({34'd0, radius})) >>> FB);
            innov = meas - v;
            mag = innov < 0 ? -innov : innov;
            r = 66'(r_noise);
            if (mag > 66'(gate)) r = r * 66'(rej_gain);
            den = p + r;
            k = den != 0 ? (p << FB) / den : 66'd0;
            if (k > one) k = one;
            upd = clamp32(v + ((innov * $signed(k)) >>> FB));
            p = ((one - k) * p) >> FB;
            speed_pred = upd[31:0];
            var_pred = p[31:0];
        end
        expected_speeds.push_back(speed_pred);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PROCESS_NOISE:     q_noise = val;
            REG_MEASUREMENT_NOISE: r_noise = val;
            REG_WHEEL_RADIUS:      radius = val;
            REG_SLIP_GATE:         gate = val;
            REG_REJECT_GAIN:       rej_gain = val[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || expected_speeds.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 2);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_wheel_beat driving_beat();
        t_wheel_beat b;
        int base;
        base = $urandom_range(0, 300 << FB) - (20 << FB);
        b.fl = base + $signed($urandom_range(0, 4 << FB)) - (2 << FB);
        b.fr = base + $signed($urandom_range(0, 4 << FB)) - (2 << FB);
        if ($urandom_range(0, 9) == 0) b.fr = base + $signed($urandom_range(0, 200 << FB));
        b.ax = $signed($urandom_range(0, 20 << FB)) - (10 << FB);
        b.dt = $urandom_range(1, 1 << (FB - 4));
        if ($urandom_range(0, 15) == 0) b.dt = -$signed($urandom_range(0, 100));
        return b;
    endfunction

    // input beat taken at the last rising edge
    always @(posedge i_clk) begin
        in_fired <= in_ch.valid && in_ch.ready;
    end

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fired) begin
            if (in_fired) begin
                void'(pending_beats.pop_front());
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                in_ch.valid <= 1'b1;
                {in_ch.front_left_rate, in_ch.front_right_rate,
                 in_ch.longitudinal_accel, in_ch.time_step} <= pending_beats[0];
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase = stall_phase + 1;
        if (stall_phase[10])
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0) && (stall_phase[5:3] != 3'd5);
    end

    // monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                kalman_predict({in_ch.front_left_rate, in_ch.front_right_rate,
                                in_ch.longitudinal_accel, in_ch.time_step});
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_speeds.size() == 0) begin
                    $error("unexpected speed_estimate beat: actual %0d", out_ch.speed_estimate);
                    errors++;
                end else begin
                    if (out_ch.speed_estimate !== expected_speeds[0]) begin
                        $error("speed_estimate: expected %0d actual %0d",
                               expected_speeds[0], out_ch.speed_estimate);
                        errors++;
                    end
                    void'(expected_speeds.pop_front());
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || run_done)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("vehicle_speed_kalman_estimator_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_wheel_beat b;
        in_ch.valid = 1'b0;
        in_ch.front_left_rate = '0;
        in_ch.front_right_rate = '0;
        in_ch.longitudinal_accel = '0;
        in_ch.time_step = '0;
        out_ch.ready = 1'b0;
        q_noise = 32'd3277 << (FB - 16);
        r_noise = 32'd32768 << (FB - 16);
        radius = 32'd16646 << (FB - 16);
        gate = 32'd131072 << (FB - 16);
        rej_gain = 8'd50;
        speed_pred = '0;
        var_pred = 32'd1 << FB;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, nonpositive time step, gating
        pending_beats.push_back('{0, 0, 0, 0});
        pending_beats.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        pending_beats.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF});
        pending_beats.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000});
        pending_beats.push_back('{-1, -1, -1, -1});
        pending_beats.push_back('{100 << FB, 100 << FB, 0, 1 << FB});
        pending_beats.push_back('{100 << FB, 40 << FB, 2 << FB, 1 << (FB - 6)});
        pending_beats.push_back('{1, 0, -1, 1});
        pending_beats.push_back('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'sh2AAA_AAAA});
        pending_beats.push_back('{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555});
        wait_idle();

        // zero noise and zero reject gain: zero denominator path
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_MEASUREMENT_NOISE, 32'd0);
        write_reg(REG_REJECT_GAIN, 32'd0);
        write_reg(REG_SLIP_GATE, 32'd0);
        pending_beats.push_back('{50 << FB, 50 << FB, 1 << FB, 1 << FB});
        pending_beats.push_back('{-50 << FB, 10 << FB, 0, 1 << FB});
        wait_idle();
        write_reg(REG_SLIP_GATE, 32'hFFFF_FFFF);
        write_reg(REG_WHEEL_RADIUS, 32'hFFFF_FFFF);
        pending_beats.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1});
        pending_beats.push_back('{-(1 << FB), -(1 << FB), 32'sh8000_0000, 32'sh7FFF_FFFF});
        wait_idle();

        // random phases across register settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 1) begin
                write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
                write_reg(REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
                write_reg(REG_REJECT_GAIN, 32'd255);
            end else if (ph == 2) begin
                write_reg(REG_PROCESS_NOISE, 32'd3277);
                write_reg(REG_MEASUREMENT_NOISE, 32'd32768);
                write_reg(REG_WHEEL_RADIUS, 32'd16646);
                write_reg(REG_SLIP_GATE, 32'd131072);
                write_reg(REG_REJECT_GAIN, 32'd1);
            end else if (ph > 2) begin
                write_reg(REG_PROCESS_NOISE, $urandom_range(0, 1 << FB));
                write_reg(REG_MEASUREMENT_NOISE, $urandom_range(0, 4 << FB));
                write_reg(REG_WHEEL_RADIUS, $urandom_range(1 << (FB - 3), 1 << FB));
                write_reg(REG_SLIP_GATE, ($urandom_range(0, 7) == 0) ? rnd32() :
                          $urandom_range(0, 8 << FB));
                write_reg(REG_REJECT_GAIN, $urandom_range(1, 255));
                if (ph == 7) write_reg(t_reg_idx'(UNUSED_IDX), $urandom());
            end
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    b.fl = rnd32();
                    b.fr = rnd32();
                    b.ax = rnd32();
                    b.dt = rnd32();
                end else begin
                    b = driving_beat();
                end
                pending_beats.push_back(b);
            end
            wait_idle();
        end

        run_done = 1'b1;
        if (errors == 0 && expected_speeds.size() == 0)
            $display("vehicle_speed_kalman_estimator_unit verification clean");
        else
            $display("vehicle_speed_kalman_estimator_unit verification failed");
        $finish;
    end

endmodule

[filelist.f]
design/vsk_pkg.sv
design/vsk_in_if.sv
design/vsk_out_if.sv
design/vsk_mul.sv
design/vsk_div.sv
design/vehicle_speed_kalman_estimator_unit.sv
tb/tb_top.sv
